FILE: hdl/fpm_pkg.sv
// shared constants and types for the fuzzy partition membership core
package fpm_pkg;

	localparam int VALUE_BITS = 16;
	localparam int MAX_SETS   = 7;
	localparam int POS_REGS   = 7;
	localparam int IDX_W      = 3;
	localparam int COUNT_W    = 3;
	localparam int FRAC_BITS  = 15;
	localparam int MEM_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = VALUE_BITS;

	localparam logic [COUNT_W-1:0] MAX_COUNT       = COUNT_W'(MAX_SETS);
	localparam logic [COUNT_W-1:0] SET_COUNT_RESET = COUNT_W'(1);
	localparam logic [MEM_W-1:0]   ONE_Q15         = MEM_W'(1) << FRAC_BITS;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_POS_BASE  = CFG_IDX_W'(1);

	typedef logic [POS_REGS-1:0][VALUE_BITS-1:0] pos_arr_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] sample;
		logic [IDX_W-1:0]             set_index;
	} item_t;

	typedef struct packed {
		logic [MEM_W-1:0] membership;
		logic             bad_index;
	} result_t;

	// one item in flight through the divider chain
	typedef struct packed {
		logic [VALUE_BITS-1:0] rem;
		logic [VALUE_BITS-1:0] den;
		logic [FRAC_BITS-1:0]  quo;
		logic                  use_div;
		logic                  one;
		logic                  bad;
	} pipe_t;

	// flow control between neighboring stages
	typedef struct packed {
		logic valid;
		logic hold;
	} flow_t;

endpackage

FILE: hdl/fpm_front.sv
// front stage: set selection, edge decision and divider operands
module fpm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  fpm_pkg::item_t   item,
	input  logic [fpm_pkg::COUNT_W-1:0] set_count,
	input  fpm_pkg::pos_arr_t pos,
	input  logic             down_hold,
	output fpm_pkg::flow_t   flow,
	output fpm_pkg::pipe_t   data_s1
);
	import fpm_pkg::*;

	logic                         valid_q;
	logic [COUNT_W-1:0]           count;
	logic [COUNT_W-1:0]           last;
	logic [IDX_W-1:0]             idx;
	logic [IDX_W-1:0]             idx_prev;
	logic [IDX_W-1:0]             idx_next;
	logic signed [VALUE_BITS-1:0] x;
	logic signed [VALUE_BITS-1:0] peak;
	logic signed [VALUE_BITS-1:0] prev;
	logic signed [VALUE_BITS-1:0] next;
	logic [VALUE_BITS-1:0]        rise_num;
	logic [VALUE_BITS-1:0]        rise_den;
	logic [VALUE_BITS-1:0]        fall_num;
	logic [VALUE_BITS-1:0]        fall_den;
	pipe_t                        nxt;
	logic                         hold;

	assign hold = valid_q && down_hold;
	assign flow = '{valid: valid_q, hold: hold};

	always_comb begin
		count    = (set_count > MAX_COUNT) ? MAX_COUNT : set_count;
		last     = count - COUNT_W'(1);
		idx      = item.set_index;
		idx_prev = (idx == '0) ? idx : idx - IDX_W'(1);
		idx_next = (idx == IDX_W'(POS_REGS - 1)) ? idx : idx + IDX_W'(1);
		x        = item.sample;
		peak     = pos[idx];
		prev     = pos[idx_prev];
		next     = pos[idx_next];
		// differences are positive and below 2**VALUE_BITS where they are used
		rise_num = x - prev;
		rise_den = peak - prev;
		fall_num = next - x;
		fall_den = next - peak;

		nxt         = '0;
		nxt.den     = VALUE_BITS'(1);
		if (COUNT_W'(idx) >= count) begin
			nxt.bad = 1'b1;
		end else if (x == peak) begin
			nxt.one = 1'b1;
		end else if (COUNT_W'(idx) == last || (idx != '0 && x < peak)) begin
			if (x > peak || idx == '0) begin
				nxt.one = 1'b1;
			end else if (x > prev) begin
				nxt.use_div = 1'b1;
				nxt.rem     = rise_num;
				nxt.den     = rise_den;
			end
		end else if (x < peak) begin
			nxt.one = 1'b1;
		end else if (x < next) begin
			nxt.use_div = 1'b1;
			nxt.rem     = fall_num;
			nxt.den     = fall_den;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!hold) begin
			valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			data_s1 <= nxt;
		end
	end

endmodule

FILE: hdl/fpm_cell.sv
// divider cell: one restoring step, one quotient bit per stage
module fpm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	input  fpm_pkg::pipe_t up,
	input  logic           down_hold,
	output fpm_pkg::flow_t flow,
	output fpm_pkg::pipe_t data_q
);
	import fpm_pkg::*;

	logic                  valid_q;
	logic                  hold;
	logic [VALUE_BITS:0]   rem2;
	logic [VALUE_BITS-1:0] diff;
	logic                  take;
	pipe_t                 nxt;

	assign hold = valid_q && down_hold;
	assign flow = '{valid: valid_q, hold: hold};

	always_comb begin
		rem2     = {up.rem, 1'b0};
		diff     = rem2[VALUE_BITS-1:0] - up.den;
		take     = (rem2 >= {1'b0, up.den});
		nxt      = up;
		nxt.rem  = take ? diff : rem2[VALUE_BITS-1:0];
		nxt.quo  = {up.quo[FRAC_BITS-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!hold) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			data_q <= nxt;
		end
	end

endmodule

FILE: hdl/fuzzy_partition_membership_core.sv
// top level: configuration registers, front stage and divider cell chain
//
// Evaluates one set of an ordered fuzzy partition at a Q8.8 sample and returns
// its membership in unsigned Q1.15 (32768 is 1.0) with a flag for a set index
// at or beyond set_count. One item is accepted every cycle while item_stall is
// low; each result passes through one front stage that picks the edge and its
// operands, then a chain of 15 divider cells, each producing one quotient bit,
// the last of which holds the result for the output transfer. When the output
// stalls, bubbles in the chain still close up, so input transfers continue
// until the chain is full. The user must write configuration only while the
// block is idle; the block itself does not enforce it.
module fuzzy_partition_membership_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  fpm_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output fpm_pkg::result_t                 result
);
	import fpm_pkg::*;

	logic [COUNT_W-1:0] set_count_q;
	pos_arr_t           pos_q;
	logic [CFG_IDX_W-1:0] pos_sel;

	flow_t              flow    [FRAC_BITS+1];
	pipe_t              data    [FRAC_BITS+1];
	logic               hold_in [FRAC_BITS+2];

	assign pos_sel = cfg_index - REG_POS_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count_q <= SET_COUNT_RESET;
			pos_q       <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_SET_COUNT) begin
				set_count_q <= cfg_data[COUNT_W-1:0];
			end else begin
				pos_q[pos_sel] <= cfg_data[VALUE_BITS-1:0];
			end
		end
	end

	assign hold_in[FRAC_BITS+1] = result_stall;

	fpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.set_count  (set_count_q),
		.pos        (pos_q),
		.down_hold  (hold_in[1]),
		.flow       (flow[0]),
		.data_s1    (data[0])
	);
	assign hold_in[0] = flow[0].hold;

	for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_cell
		fpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.up_valid  (flow[i-1].valid),
			.up        (data[i-1]),
			.down_hold (hold_in[i+1]),
			.flow      (flow[i]),
			.data_q    (data[i])
		);
		assign hold_in[i] = flow[i].hold;
	end

	assign item_stall   = hold_in[0];
	assign result_valid = flow[FRAC_BITS].valid;

	always_comb begin
		result.bad_index = data[FRAC_BITS].bad;
		if (data[FRAC_BITS].use_div) begin
			result.membership = MEM_W'(data[FRAC_BITS].quo);
		end else if (data[FRAC_BITS].one) begin
			result.membership = ONE_Q15;
		end else begin
			result.membership = '0;
		end
	end

endmodule
